[rtl/dpt_pkg.sv]
// types, codes and sizes shared by the dominating point table
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

	// table size and coordinate width
	localparam int CAPACITY = 64;
	localparam int COORD_W  = 30;

	// command codes
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_DUP     = 2'd3;

	// request transaction
	typedef struct packed {
		logic [1:0]         cmd;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
	} req_t;

	// response transaction
	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [1:0]         status;
	} rsp_t;

	// token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic [1:0]         cmd;
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
		logic               hit;
		logic               placed;
		logic               found;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by;
	} tok_t;

	// end-of-scan decision for a tentatively placed point
	typedef struct packed {
		logic en;
		logic ok;
	} commit_t;

endpackage

`default_nettype wire

[rtl/dpt_cell.sv]
// one table slot: holds a point and updates the passing token
`timescale 1ns / 1ps
`default_nettype none

module dpt_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dpt_pkg::tok_t    tok_in,
	input  wire dpt_pkg::commit_t commit,
	output dpt_pkg::tok_t         tok_out
);
	import dpt_pkg::*;

	logic               vld_q;
	logic               pend_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	tok_t               tok_d;
	tok_t               tok_q;
	logic               match;
	logic               dom;
	logic               better;
	logic               place;
	logic               drop;

	// compares against the stored point
	assign match  = vld_q && (x_q == tok_in.qx) && (y_q == tok_in.qy);
	assign dom    = vld_q && (x_q > tok_in.qx) && (y_q > tok_in.qy);
	assign better = !tok_in.found || (x_q < tok_in.bx) ||
	                ((x_q == tok_in.bx) && (y_q < tok_in.by));

	// token update
	always_comb begin
		tok_d = tok_in;
		place = 1'b0;
		drop  = 1'b0;
		if (tok_in.valid) begin
			unique case (tok_in.cmd)
				CMD_ADD: begin
					tok_d.hit = tok_in.hit | match;
					if (!vld_q && !pend_q && !tok_in.placed && !tok_in.hit) begin
						place        = 1'b1;
						tok_d.placed = 1'b1;
					end
				end
				CMD_REMOVE: begin
					tok_d.hit = tok_in.hit | match;
					drop      = match;
				end
				CMD_FIND: begin
					if (dom && better) begin
						tok_d.found = 1'b1;
						tok_d.bx    = x_q;
						tok_d.by    = y_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// slot valid and pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			pend_q <= 1'b0;
		end else if (commit.en && pend_q) begin
			vld_q  <= commit.ok;
			pend_q <= 1'b0;
		end else if (place) begin
			pend_q <= 1'b1;
		end else if (drop) begin
			vld_q <= 1'b0;
		end
	end

	// stored point
	always_ff @(posedge clk) begin
		if (place) begin
			x_q <= tok_in.qx;
			y_q <= tok_in.qy;
		end
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

[rtl/dominating_point_table_core.sv]
// dominating point table: chain of slot cells with request and response stages
//
//   channel   dir   payload   handshake
//   req       in    req_t     req_valid / req_stall
//   rsp       out   rsp_t     rsp_valid / rsp_stall
//
// One transaction at a time: a token walks the cell chain, one cell per cycle,
// so its result reaches the hold register and then the response register; the next
// request waits until the scan ends and the hold register is empty, and is held off
// further while a stalled response keeps the hold register full.
// An add places the point in the first free cell and commits it when the scan
// shows no duplicate. Reset clears all slot valid bits at once.
// A waiting response does not block the next request; a second finished
// result parks in a hold register until the response register drains.
`timescale 1ns / 1ps
`default_nettype none

module dominating_point_table_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire dpt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output dpt_pkg::rsp_t      rsp
);
	import dpt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t  state_q;
	tok_t    chain [CAPACITY+1];
	tok_t    tok_end;
	tok_t    tok_new;
	tok_t    tok_q;
	commit_t commit;
	rsp_t    res;
	rsp_t    hold_q;
	logic    hold_vld_q;
	rsp_t    rsp_q;
	logic    rsp_vld_q;
	logic    accept;
	logic    move;

	assign req_stall = (state_q != S_IDLE) || hold_vld_q;
	assign accept    = req_valid && !req_stall;
	assign tok_end   = chain[CAPACITY];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_SCAN;
				S_SCAN: if (tok_end.valid) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// fresh token built from the request
	always_comb begin
		tok_new       = '0;
		tok_new.valid = accept;
		tok_new.cmd   = req.cmd;
		tok_new.qx    = req.x_coord;
		tok_new.qy    = req.y_coord;
	end

	// token launch into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_new;
		end
	end

	assign chain[0] = tok_q;

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		dpt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.commit  (commit),
			.tok_out (chain[i+1])
		);
	end

	// commit or cancel the tentative add
	assign commit = '{en: tok_end.valid && (tok_end.cmd == CMD_ADD),
	                  ok: tok_end.placed && !tok_end.hit};

	// result from the finished token
	always_comb begin
		res = '0;
		unique case (tok_end.cmd)
			CMD_ADD: begin
				if (tok_end.hit) begin
					res.status = ST_DUP;
				end else if (!tok_end.placed) begin
					res.status = ST_FULL;
				end else begin
					res.status = ST_OK;
				end
			end
			CMD_REMOVE: res.status = tok_end.hit ? ST_OK : ST_MISSING;
			CMD_FIND: begin
				res.found   = tok_end.found;
				res.point_x = tok_end.bx;
				res.point_y = tok_end.by;
				res.status  = ST_OK;
			end
			default: res = '0;
		endcase
	end

	assign move = hold_vld_q && (!rsp_vld_q || !rsp_stall);

	// hold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
		end else if (tok_end.valid) begin
			hold_vld_q <= 1'b1;
		end else if (move) begin
			hold_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			hold_q <= res;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (move) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rsp_q <= hold_q;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/dpt_checker.sv]
// port-level checks for the dominating point table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module dpt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire dpt_pkg::rsp_t rsp
);
	import dpt_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one transaction in flight: stall right after acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

	// a found point comes with ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == ST_OK)
		else $error("found point with error status");

	// no point reported when nothing was found
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.point_x == '0 && rsp.point_y == '0)
		else $error("coordinates set without a found point");

endmodule

bind dominating_point_table_core dpt_checker u_dpt_checker (.*);

`default_nettype wire
